[hdl/ntpc_pkg.sv]
// shared constants, lookup tables and widths for the note to pitch converter
package ntpc_pkg;

    // field widths
    localparam int unsigned FINE_W  = 15;
    localparam int unsigned NOTE_W  = 7;
    localparam int unsigned CFINE_W = 7;
    localparam int unsigned CNOTE_W = 8;
    localparam int unsigned PITCH_W = 16;

    // semitone offset biased to stay positive, and its octave split
    localparam int unsigned SEMI_W   = 10;
    localparam int unsigned OCT_W    = 6;
    localparam int unsigned IDX_W    = 4;
    localparam int unsigned FRAC_W   = 7;
    localparam logic [SEMI_W-1:0] SEMI_BIAS = 10'd288;

    // floor(x / 12) as (x * 683) >> 13, exact for x below 1024 * 0.75
    localparam logic [SEMI_W-1:0] RECIP12       = 10'd683;
    localparam int unsigned       RECIP12_SHIFT = 13;
    localparam logic [IDX_W-1:0]  NOTES_PER_OCT = 4'd12;

    // biased octave at which no downward shift applies (reference octave 2)
    localparam logic [OCT_W-1:0] REF_OCT_BIASED = 6'd26;
    localparam int unsigned      SHIFT_W = 5;
    localparam int unsigned      ROUND_W = 25;

    // 44100 / 48000 as a 28-bit fraction, rounded up so floor stays exact
    localparam int unsigned       LEGACY_SHIFT = 28;
    localparam logic [27:0]       LEGACY_MULT  = 28'd246625076;

    // equal-tempered step within one octave
    function automatic logic [15:0] note_rom(input logic [IDX_W-1:0] idx);
        logic [15:0] val;
        case (idx)
            4'd0:    val = 16'h8000;
            4'd1:    val = 16'h879C;
            4'd2:    val = 16'h8FAC;
            4'd3:    val = 16'h9837;
            4'd4:    val = 16'hA145;
            4'd5:    val = 16'hAADC;
            4'd6:    val = 16'hB504;
            4'd7:    val = 16'hBFC8;
            4'd8:    val = 16'hCB2F;
            4'd9:    val = 16'hD744;
            4'd10:   val = 16'hE411;
            4'd11:   val = 16'hF1A1;
            default: val = 16'h8000;
        endcase
        return val;
    endfunction

    // 1/128 semitone steps
    localparam logic [15:0] FRAC_ROM [128] = '{
        16'h8000, 16'h800E,
        16'h801D, 16'h802C, 16'h803B, 16'h804A, 16'h8058, 16'h8067, 16'h8076,
        16'h8085, 16'h8094, 16'h80A3, 16'h80B1, 16'h80C0, 16'h80CF, 16'h80DE,
        16'h80ED, 16'h80FC, 16'h810B, 16'h811A, 16'h8129, 16'h8138, 16'h8146,
        16'h8155, 16'h8164, 16'h8173, 16'h8182, 16'h8191, 16'h81A0, 16'h81AF,
        16'h81BE, 16'h81CD, 16'h81DC, 16'h81EB, 16'h81FA, 16'h8209, 16'h8218,
        16'h8227, 16'h8236, 16'h8245, 16'h8254, 16'h8263, 16'h8272, 16'h8282,
        16'h8291, 16'h82A0, 16'h82AF, 16'h82BE, 16'h82CD, 16'h82DC, 16'h82EB,
        16'h82FA, 16'h830A, 16'h8319, 16'h8328, 16'h8337, 16'h8346, 16'h8355,
        16'h8364, 16'h8374, 16'h8383, 16'h8392, 16'h83A1, 16'h83B0, 16'h83C0,
        16'h83CF, 16'h83DE, 16'h83ED, 16'h83FD, 16'h840C, 16'h841B, 16'h842A,
        16'h843A, 16'h8449, 16'h8458, 16'h8468, 16'h8477, 16'h8486, 16'h8495,
        16'h84A5, 16'h84B4, 16'h84C3, 16'h84D3, 16'h84E2, 16'h84F1, 16'h8501,
        16'h8510, 16'h8520, 16'h852F, 16'h853E, 16'h854E, 16'h855D, 16'h856D,
        16'h857C, 16'h858B, 16'h859B, 16'h85AA, 16'h85BA, 16'h85C9, 16'h85D9,
        16'h85E8, 16'h85F8, 16'h8607, 16'h8617, 16'h8626, 16'h8636, 16'h8645,
        16'h8655, 16'h8664, 16'h8674, 16'h8683, 16'h8693, 16'h86A2, 16'h86B2,
        16'h86C1, 16'h86D1, 16'h86E0, 16'h86F0, 16'h8700, 16'h870F, 16'h871F,
        16'h872E, 16'h873E, 16'h874E, 16'h875D, 16'h876D, 16'h877D, 16'h878C
    };

endpackage

[hdl/note_to_pitch_converter_unit.sv]
// Note to pitch converter: five-stage pipeline from note and fine tune to pitch word
//
// Usage:
//   Input channel (in_valid / in_stall) carries op, base_note, base_fine,
//   play_note and play_fine. A transfer happens on a clock edge with in_valid
//   high and in_stall low. Each transfer produces exactly one pitch_word on
//   the output channel (out_valid / out_stall), in order.
//   When the output is not stalled, each item passes in order through the
//   five pipeline registers (fine split, octave split, ROM multiply, octave
//   shift, legacy rate multiply), each of which holds one item, and out_valid
//   rises once the item reaches the last. Throughput is one item per cycle
//   while the output is not stalled.
//   When out_stall is held, the result stays on pitch_word and the pipeline
//   fills up; empty stages still close up, so in_stall rises only once all
//   five stages hold an item.
//   rst_n is asynchronous and active low; it empties the pipeline. There is
//   no configuration and no state carried between items.
module note_to_pitch_converter_unit
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           op,
    input  logic signed [ntpc_pkg::CNOTE_W-1:0] base_note,
    input  logic [ntpc_pkg::CFINE_W-1:0]   base_fine,
    input  logic [ntpc_pkg::NOTE_W-1:0]    play_note,
    input  logic signed [ntpc_pkg::FINE_W-1:0]  play_fine,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [ntpc_pkg::PITCH_W-1:0]   pitch_word
);
    import ntpc_pkg::*;

    // stage valid bits and advance enables
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic en1, en2, en3, en4, en5;

    assign en5 = !v5_reg || !out_stall;
    assign en4 = !v4_reg || en5;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign in_stall  = !en1;
    assign out_valid = v5_reg;

    // stage 1: fine sum, semitone offset
    logic               neg_center;
    logic               scale_next;
    logic signed [8:0]  center;
    logic signed [15:0] fine_sum;
    logic signed [8:0]  whole;
    logic [SEMI_W-1:0]  semi_next;
    logic [SEMI_W-1:0]  semi1_reg;
    logic [FRAC_W-1:0]  frac1_reg;
    logic               scale1_reg;

    assign neg_center = base_note[CNOTE_W-1];
    assign scale_next = op && !neg_center;
    assign center     = (op && neg_center) ? (9'sd0 - 9'(base_note)) : 9'(base_note);
    assign fine_sum   = 16'(play_fine) + $signed({9'd0, base_fine});
    assign whole      = fine_sum[15:FRAC_W];
    assign semi_next  = {3'd0, play_note} + SEMI_W'(whole) - SEMI_W'(center) + SEMI_BIAS;

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            semi1_reg  <= semi_next;
            frac1_reg  <= fine_sum[FRAC_W-1:0];
            scale1_reg <= scale_next;
        end
    end

    // stage 2: octave and note within the octave
    logic [OCT_W-1:0]  oct_next;
    logic [IDX_W-1:0]  idx_next;
    logic [OCT_W-1:0]  oct2_reg;
    logic [IDX_W-1:0]  idx2_reg;
    logic [FRAC_W-1:0] frac2_reg;
    logic              scale2_reg;

    ntpc_divmod12 u_divmod
    (
        .semi     (semi1_reg),
        .octave   (oct_next),
        .note_idx (idx_next)
    );

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            oct2_reg   <= oct_next;
            idx2_reg   <= idx_next;
            frac2_reg  <= frac1_reg;
            scale2_reg <= scale1_reg;
        end
    end

    // stage 3: ROM product
    logic [31:0]        rom_prod;
    logic [PITCH_W-1:0] prod3_reg;
    logic [OCT_W-1:0]   oct3_reg;
    logic               scale3_reg;

    assign rom_prod = 32'(note_rom(idx2_reg)) * 32'(FRAC_ROM[frac2_reg]);

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            prod3_reg  <= rom_prod[31:16];
            oct3_reg   <= oct2_reg;
            scale3_reg <= scale2_reg;
        end
    end

    // stage 4: rounded downward shift for low octaves
    logic [SHIFT_W-1:0] shift_amt;
    logic [ROUND_W-1:0] round_sum;
    logic [ROUND_W-1:0] round_shifted;
    logic [PITCH_W-1:0] pitch_next;
    logic [PITCH_W-1:0] pitch4_reg;
    logic               scale4_reg;

    assign shift_amt     = SHIFT_W'(REF_OCT_BIASED - oct3_reg);
    assign round_sum     = ROUND_W'(prod3_reg) + (ROUND_W'(1) << (shift_amt - SHIFT_W'(1)));
    assign round_shifted = round_sum >> shift_amt;
    assign pitch_next    = (oct3_reg < REF_OCT_BIASED) ? round_shifted[PITCH_W-1:0]
                                                       : prod3_reg;

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            pitch4_reg <= pitch_next;
            scale4_reg <= scale3_reg;
        end
    end

    // stage 5: legacy rate scaling for legacy items with a non-negative center note, into the output register
    logic [PITCH_W+LEGACY_SHIFT-1:0] legacy_prod;
    logic [PITCH_W-1:0]              pitch_word_reg;

    assign legacy_prod = (PITCH_W+LEGACY_SHIFT)'(pitch4_reg)
                       * (PITCH_W+LEGACY_SHIFT)'(LEGACY_MULT);

    always_ff @(posedge clk)
    begin
        if (en5)
        begin
            pitch_word_reg <= scale4_reg ? legacy_prod[LEGACY_SHIFT +: PITCH_W] : pitch4_reg;
        end
    end

    assign pitch_word = pitch_word_reg;

    // valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= in_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
            if (en5) v5_reg <= v4_reg;
        end
    end

endmodule

[hdl/ntpc_divmod12.sv]
// splits a biased semitone count into octave and note within the octave
module ntpc_divmod12
(
    input  logic [ntpc_pkg::SEMI_W-1:0] semi,
    output logic [ntpc_pkg::OCT_W-1:0]  octave,
    output logic [ntpc_pkg::IDX_W-1:0]  note_idx
);
    import ntpc_pkg::*;

    logic [2*SEMI_W-1:0] recip_prod;
    logic [SEMI_W-1:0]   oct_times12;
    logic [SEMI_W-1:0]   remainder;

    // quotient by reciprocal multiply
    assign recip_prod = (2*SEMI_W)'(semi) * (2*SEMI_W)'(RECIP12);
    assign octave     = recip_prod[RECIP12_SHIFT +: OCT_W];

    // remainder from the quotient
    assign oct_times12 = SEMI_W'(octave) * SEMI_W'(NOTES_PER_OCT);
    assign remainder   = semi - oct_times12;
    assign note_idx    = remainder[IDX_W-1:0];

endmodule

[hdl/ntpc_checker.sv]
// port-level checks for the note to pitch converter, bound to the top level
module ntpc_checker
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_stall,
    input  logic                           op,
    input  logic signed [ntpc_pkg::CNOTE_W-1:0] base_note,
    input  logic [ntpc_pkg::CFINE_W-1:0]   base_fine,
    input  logic [ntpc_pkg::NOTE_W-1:0]    play_note,
    input  logic signed [ntpc_pkg::FINE_W-1:0]  play_fine,
    input  logic                           out_valid,
    input  logic                           out_stall,
    input  logic [ntpc_pkg::PITCH_W-1:0]   pitch_word
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("out_valid dropped while stalled");

    // a stalled result keeps its value
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(pitch_word))
        else $error("pitch_word changed while stalled");

    // input backpressure only comes from a stalled output
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output backpressure");

    // a transfer reaches out_valid through every stage when the output flows
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall ##1 !out_stall ##1 !out_stall ##1 !out_stall
        ##1 !out_stall |=> out_valid)
        else $error("result missing five cycles after transfer");

endmodule

bind note_to_pitch_converter_unit ntpc_checker u_ntpc_checker (.*);

[sim/tb_note_to_pitch_converter_unit.sv]
// testbench for the note to pitch converter: directed and random transfers against a predictor
`timescale 1ns / 100ps

typedef enum bit {OP_NATIVE = 1'b0, OP_LEGACY = 1'b1} pitch_op_t;

typedef enum int {RX_FLOW, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_t;

typedef struct {
    pitch_op_t                             op;
    logic signed [ntpc_pkg::CNOTE_W-1:0]   base_note;
    logic [ntpc_pkg::CFINE_W-1:0]          base_fine;
    logic [ntpc_pkg::NOTE_W-1:0]           play_note;
    logic signed [ntpc_pkg::FINE_W-1:0]    play_fine;
} note_req_t;

class pitch_scoreboard;
    logic [15:0] pitch_q[$];
    logic [15:0] semitone_tab[12];
    logic [15:0] cent_tab[128];
    int n_checked;
    int n_native;
    int n_legacy;
    int n_below_unity;
    int n_errors;

    function new();
        semitone_tab = '{
            16'h8000, 16'h879C, 16'h8FAC, 16'h9837, 16'hA145, 16'hAADC, 16'hB504,
            16'hBFC8, 16'hCB2F, 16'hD744, 16'hE411, 16'hF1A1
        };
        cent_tab = '{
            16'h8000, 16'h800E,
            16'h801D, 16'h802C, 16'h803B, 16'h804A, 16'h8058, 16'h8067, 16'h8076,
            16'h8085, 16'h8094, 16'h80A3, 16'h80B1, 16'h80C0, 16'h80CF, 16'h80DE,
            16'h80ED, 16'h80FC, 16'h810B, 16'h811A, 16'h8129, 16'h8138, 16'h8146,
            16'h8155, 16'h8164, 16'h8173, 16'h8182, 16'h8191, 16'h81A0, 16'h81AF,
            16'h81BE, 16'h81CD, 16'h81DC, 16'h81EB, 16'h81FA, 16'h8209, 16'h8218,
            16'h8227, 16'h8236, 16'h8245, 16'h8254, 16'h8263, 16'h8272, 16'h8282,
            16'h8291, 16'h82A0, 16'h82AF, 16'h82BE, 16'h82CD, 16'h82DC, 16'h82EB,
            16'h82FA, 16'h830A, 16'h8319, 16'h8328, 16'h8337, 16'h8346, 16'h8355,
            16'h8364, 16'h8374, 16'h8383, 16'h8392, 16'h83A1, 16'h83B0, 16'h83C0,
            16'h83CF, 16'h83DE, 16'h83ED, 16'h83FD, 16'h840C, 16'h841B, 16'h842A,
            16'h843A, 16'h8449, 16'h8458, 16'h8468, 16'h8477, 16'h8486, 16'h8495,
            16'h84A5, 16'h84B4, 16'h84C3, 16'h84D3, 16'h84E2, 16'h84F1, 16'h8501,
            16'h8510, 16'h8520, 16'h852F, 16'h853E, 16'h854E, 16'h855D, 16'h856D,
            16'h857C, 16'h858B, 16'h859B, 16'h85AA, 16'h85BA, 16'h85C9, 16'h85D9,
            16'h85E8, 16'h85F8, 16'h8607, 16'h8617, 16'h8626, 16'h8636, 16'h8645,
            16'h8655, 16'h8664, 16'h8674, 16'h8683, 16'h8693, 16'h86A2, 16'h86B2,
            16'h86C1, 16'h86D1, 16'h86E0, 16'h86F0, 16'h8700, 16'h870F, 16'h871F,
            16'h872E, 16'h873E, 16'h874E, 16'h875D, 16'h876D, 16'h877D, 16'h878C
        };
    endfunction

    // pitch step for one request
    function logic [15:0] predict_pitch(note_req_t r);
        int center;
        int fine_sum;
        int semis_off;
        int frac;
        int semis;
        int octave;
        int idx;
        int shift;
        bit rescale;
        longint unsigned prod;
        center = int'(r.base_note);
        rescale = 1'b0;
        // legacy: sign of center note picks rescale or negation
        if (r.op == OP_LEGACY)
        begin
            if (center >= 0)
            begin
                rescale = 1'b1;
            end
            else
            begin
                center = -center;
            end
        end
        // floor split of the fine sum into semitones and 1/128 steps
        fine_sum = int'(r.play_fine) + int'(r.base_fine);
        semis_off = (fine_sum + 16384) / 128 - 128;
        frac = fine_sum - semis_off * 128;
        // floor split of the semitone offset into octave and note
        semis = int'(r.play_note) + semis_off - center;
        octave = (semis + 288) / 12 - 24;
        idx = semis - octave * 12;
        prod = longint'(semitone_tab[idx]);
        prod = (prod * longint'(cent_tab[frac])) >> 16;
        // octaves below the reference shift down with rounding
        shift = 2 - octave;
        if (shift >= 32)
        begin
            prod = 0;
        end
        else if (shift > 0)
        begin
            prod = (prod + (64'd1 << (shift - 1))) >> shift;
        end
        prod = prod & 64'hFFFF;
        if (rescale)
        begin
            prod = (prod * 64'd44100) / 64'd48000;
        end
        return prod[15:0];
    endfunction

    function void note_request(note_req_t r);
        logic [15:0] want;
        want = predict_pitch(r);
        pitch_q.push_back(want);
        if (r.op == OP_LEGACY)
        begin
            n_legacy++;
        end
        else
        begin
            n_native++;
        end
        if (want < 16'h1000)
        begin
            n_below_unity++;
        end
    endfunction

    task report(string what);
        $display("tb: mismatch: %s", what);
        n_errors++;
    endtask

    task check_pitch(logic [15:0] got);
        logic [15:0] want;
        if (pitch_q.size() == 0)
        begin
            report($sformatf("pitch_word %h with no transfer pending", got));
            return;
        end
        want = pitch_q.pop_front();
        n_checked++;
        if (got !== want)
        begin
            report($sformatf("pitch_word %h, expected %h (result %0d)", got, want, n_checked));
        end
    endtask
endclass

module tb_note_to_pitch_converter_unit;

    localparam int N_RANDOM      = 1000;
    localparam int N_BACK2BACK   = 30;
    localparam int HOLD_CYCLES   = 60;
    localparam int DRAIN_CYCLES  = 12;
    localparam int WATCHDOG_IDLE = 2000;

    logic clk = 1'b0;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic op;
    logic signed [ntpc_pkg::CNOTE_W-1:0] base_note;
    logic [ntpc_pkg::CFINE_W-1:0]        base_fine;
    logic [ntpc_pkg::NOTE_W-1:0]         play_note;
    logic signed [ntpc_pkg::FINE_W-1:0]  play_fine;
    logic out_valid;
    logic out_stall;
    logic [ntpc_pkg::PITCH_W-1:0]        pitch_word;

    pitch_scoreboard sb;
    note_req_t       seen_req;
    bit              hold_req;
    int              idle_cycles = 0;
    int              full_cycles = 0;
    int              sent;
    int              burst;

    note_to_pitch_converter_unit DUT
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .op         (op),
        .base_note  (base_note),
        .base_fine  (base_fine),
        .play_note  (play_note),
        .play_fine  (play_fine),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .pitch_word (pitch_word)
    );

    always #5 clk = ~clk;

    // offer one request and hold it until the transfer
    task automatic send_request(input note_req_t r);
        in_valid  <= 1'b1;
        op        <= r.op;
        base_note <= r.base_note;
        base_fine <= r.base_fine;
        play_note <= r.play_note;
        play_fine <= r.play_fine;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
    endtask

    task automatic send_fields(input pitch_op_t o, input int bn, input int bf, input int pn,
                               input int pf);
        note_req_t r;
        r.op        = o;
        r.base_note = bn[7:0];
        r.base_fine = bf[6:0];
        r.play_note = pn[6:0];
        r.play_fine = pf[14:0];
        send_request(r);
    endtask

    // gap with no request offered, its length set by n
    task automatic idle_sender(input int n);
        in_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // mostly musical requests, the rest fully random
    function automatic note_req_t random_request();
        note_req_t r;
        logic [31:0] rnd;
        int offs;
        rnd         = $urandom;
        r.op        = pitch_op_t'(rnd[31]);
        r.base_note = rnd[7:0];
        r.base_fine = rnd[14:8];
        r.play_note = rnd[21:15];
        rnd         = $urandom;
        r.play_fine = rnd[14:0];
        if ($urandom_range(0, 9) < 6)
        begin
            offs = int'($urandom_range(0, 2047)) - 1024;
            r.play_fine = offs[14:0];
            offs = int'($urandom_range(36, 84));
            r.base_note = offs[7:0];
            if (r.op == OP_LEGACY && rnd[20])
            begin
                r.base_note = -r.base_note;
            end
            offs = int'($urandom_range(24, 96));
            r.play_note = offs[6:0];
        end
        return r;
    endfunction

    // stimulus
    initial
    begin
        sb = new();
        hold_req = 1'b0;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        op        <= OP_NATIVE;
        base_note <= '0;
        base_fine <= '0;
        play_note <= '0;
        play_fine <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: field extremes, rate boundaries, both modes and center signs
        send_fields(OP_NATIVE, 0, 0, 0, 0);
        send_fields(OP_NATIVE, 24, 0, 24, 0);
        send_fields(OP_NATIVE, 0, 0, 24, 0);
        send_fields(OP_NATIVE, -128, 0, 127, 16383);
        send_fields(OP_NATIVE, 127, 0, 0, -16384);
        send_fields(OP_NATIVE, 0, 127, 127, 16383);
        send_fields(OP_NATIVE, 60, 0, 60, -1);
        send_fields(OP_NATIVE, 60, 1, 60, -1);
        send_fields(OP_NATIVE, 60, 0, 61, 0);
        send_fields(OP_NATIVE, 60, 0, 71, 64);
        send_fields(OP_NATIVE, 60, 0, 59, -64);
        send_fields(OP_NATIVE, -1, 0, 0, 0);
        send_fields(OP_NATIVE, -128, 127, 0, -16384);
        send_fields(OP_LEGACY, 0, 0, 0, 0);
        send_fields(OP_LEGACY, 127, 127, 127, 16383);
        send_fields(OP_LEGACY, 60, 0, 72, 0);
        send_fields(OP_LEGACY, -1, 0, 0, 0);
        send_fields(OP_LEGACY, -60, 0, 60, 0);
        send_fields(OP_LEGACY, -128, 0, 0, -16384);
        send_fields(OP_LEGACY, -128, 127, 127, 16383);
        send_fields(OP_LEGACY, 24, 0, 0, -16384);
        send_fields(OP_NATIVE, 85, 85, 42, 10922);
        send_fields(OP_LEGACY, -86, 42, 85, -10923);
        idle_sender(3);

        // back to back while the receiver holds off, so the pipeline fills
        hold_req = 1'b1;
        sent = 0;
        while (sent < N_BACK2BACK)
        begin
            send_request(random_request());
            sent++;
        end

        // random bursts with random gaps
        while (sent < N_RANDOM)
        begin
            burst = $urandom_range(1, 24);
            while (burst > 0 && sent < N_RANDOM)
            begin
                send_request(random_request());
                sent++;
                burst--;
            end
            if ($urandom_range(0, 3) != 0)
            begin
                idle_sender($urandom_range(1, 8));
            end
        end
        in_valid <= 1'b0;

        // drain
        while (sb.pitch_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("tb: %0d pitch words checked, %0d native and %0d legacy, %0d below unity rate",
                 sb.n_checked, sb.n_native, sb.n_legacy, sb.n_below_unity);
        $display("tb: input held off for %0d cycles by a full pipeline", full_cycles);
        if (sb.n_errors == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

    // receiver stall pattern, with one long hold-off on request
    initial
    begin : rx_stall
        rx_mode_t mode;
        int phase_left;
        int hold_left;
        bit hold_done;
        mode = RX_FLOW;
        phase_left = 0;
        hold_left = 0;
        hold_done = 1'b0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else if (hold_req && !hold_done)
            begin
                out_stall <= 1'b1;
                hold_left = HOLD_CYCLES - 1;
                hold_done = 1'b1;
            end
            else
            begin
                if (phase_left == 0)
                begin
                    mode = rx_mode_t'($urandom_range(0, 3));
                    phase_left = $urandom_range(10, 60);
                end
                phase_left--;
                case (mode)
                    RX_FLOW:
                    begin
                        out_stall <= 1'b0;
                    end
                    RX_LIGHT:
                    begin
                        out_stall <= ($urandom_range(0, 99) < 30);
                    end
                    RX_HEAVY:
                    begin
                        out_stall <= ($urandom_range(0, 99) < 75);
                    end
                    default:
                    begin
                        out_stall <= (phase_left % 4 == 0);
                    end
                endcase
            end
        end
    end

    // transfer monitors on both channels
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                seen_req.op        = pitch_op_t'(op);
                seen_req.base_note = base_note;
                seen_req.base_fine = base_fine;
                seen_req.play_note = play_note;
                seen_req.play_fine = play_fine;
                sb.note_request(seen_req);
            end
            if (in_valid && in_stall)
            begin
                full_cycles++;
            end
            if (out_valid && !out_stall)
            begin
                sb.check_pitch(pitch_word);
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_IDLE)
        begin
            $display("tb: no transfer for %0d cycles", idle_cycles);
            $display("tb: failure");
            $finish;
        end
    end

endmodule
